// ===== design/line_code_symbol_decoder_macros.svh =====
// Assertion macros for the decoder top level.
`ifndef LINE_CODE_SYMBOL_DECODER_MACROS_SVH
`define LINE_CODE_SYMBOL_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define LCSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line code decoder check failed");

// Next-cycle implication, sampled on clk and switched off during rst.
`define LCSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line code decoder check failed");

`endif

// ===== design/lcsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcsd_pkg;

  localparam int unsigned PREAMBLE_BYTES = 4;
  localparam int unsigned PREAMBLE_SYMS  = PREAMBLE_BYTES * 8;
  localparam int unsigned PRE_CNT_W      = $clog2(PREAMBLE_SYMS + 1);

  localparam int unsigned SHIFT_W     = 10;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned MAX_FRAME_W = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CNT_W:0] RAW_SYMS   = 5'd8;
  localparam logic [CNT_W:0] MANCH_SYMS = 5'd16;
  localparam logic [CNT_W:0] CODE_SYMS  = 5'd10;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_MANCHESTER = 1'b0;
  localparam logic MODE_4B5B       = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME = 1'b1;

  localparam logic [MAX_FRAME_W-1:0] MAX_FRAME_RESET = 16'd256;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SYNC = 2'd1,
    ST_CODE = 2'd2,
    ST_OVER = 2'd3
  } status_t;

  localparam logic [4:0] NIBBLE_CODES [16] = '{
    5'h1e, 5'h09, 5'h14, 5'h15, 5'h0a, 5'h0b, 5'h0e, 5'h0f,
    5'h12, 5'h13, 5'h16, 5'h17, 5'h1a, 5'h1b, 5'h1c, 5'h1d
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] nibble;
  } nibble_t;

  // One record per accepted symbol, passed from the framing front end to the back end.
  typedef struct packed {
    logic               byte_start;
    logic               pair_err;
    logic               done;
    logic               is_4b5b;
    logic [SHIFT_W-1:0] shift;
    logic               frame_end;
    logic               sync_bad;
  } sym_event_t;

  function automatic nibble_t code_to_nibble(input logic [4:0] code);
    nibble_t r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (NIBBLE_CODES[k] == code) begin
        r.hit    = 1'b1;
        r.nibble = 4'(k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/lcsd_sym_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lcsd_sym_if;
  logic valid;
  logic ready;
  logic symbol;
  logic frame_end;

  modport source (output valid, output symbol, output frame_end, input ready);
  modport sink (input valid, input symbol, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== design/lcsd_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lcsd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       frame_done;
  logic [1:0] status;

  modport source (output valid, output data_byte, output byte_valid, output frame_done,
                  output status, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input frame_done,
                input status, output ready);
endinterface

`default_nettype wire

// ===== design/lcsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcsd_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  line_mode,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_symbol,
  input  wire logic                  in_frame_end,
  input  wire logic                  q_full,
  output logic                       q_push,
  output lcsd_pkg::sym_event_t       q_data
);

  logic [lcsd_pkg::PRE_CNT_W-1:0] pre_cnt;
  logic [lcsd_pkg::PRE_CNT_W-1:0] pre_cnt_next;
  logic [lcsd_pkg::SHIFT_W-1:0]   shift;
  logic [lcsd_pkg::SHIFT_W-1:0]   shift_calc;
  logic [lcsd_pkg::SHIFT_W-1:0]   shift_next;
  logic [lcsd_pkg::CNT_W-1:0]     sym_cnt;
  logic [lcsd_pkg::CNT_W-1:0]     sym_cnt_next;
  logic [lcsd_pkg::CNT_W:0]       cnt_inc;
  logic                           pre_active;
  logic                           pair_err;
  logic                           done;
  logic                           is_4b5b;
  logic                           accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  assign pre_active = pre_cnt < lcsd_pkg::PRE_CNT_W'(lcsd_pkg::PREAMBLE_SYMS);
  assign cnt_inc    = {1'b0, sym_cnt} + 1'b1;

  always_comb begin
    pre_cnt_next = pre_cnt;
    shift_calc   = {shift[lcsd_pkg::SHIFT_W-2:0], in_symbol};
    pair_err     = 1'b0;
    is_4b5b      = 1'b0;
    if (pre_active) begin
      pre_cnt_next = pre_cnt + 1'b1;
      done         = cnt_inc >= lcsd_pkg::RAW_SYMS;
    end else if (line_mode == lcsd_pkg::MODE_MANCHESTER) begin
      // Bit 9 holds the first half of a pair; the data bits build up in the low byte.
      if (!sym_cnt[0]) begin
        shift_calc = {in_symbol, 1'b0, shift[7:0]};
      end else begin
        pair_err   = shift[9] == in_symbol;
        shift_calc = {2'b00, shift[6:0], in_symbol};
      end
      done = cnt_inc >= lcsd_pkg::MANCH_SYMS;
    end else begin
      is_4b5b = 1'b1;
      done    = cnt_inc >= lcsd_pkg::CODE_SYMS;
    end
    sym_cnt_next = done ? '0 : cnt_inc[lcsd_pkg::CNT_W-1:0];
    shift_next   = done ? '0 : shift_calc;
  end

  always_comb begin
    q_data.byte_start = sym_cnt == '0;
    q_data.pair_err   = pair_err;
    q_data.done       = done;
    q_data.is_4b5b    = is_4b5b;
    q_data.shift      = shift_calc;
    q_data.frame_end  = in_frame_end;
    q_data.sync_bad   = (pre_cnt_next < lcsd_pkg::PRE_CNT_W'(lcsd_pkg::PREAMBLE_SYMS))
                        || (sym_cnt_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_cnt <= '0;
      shift   <= '0;
      sym_cnt <= '0;
    end else if (accept) begin
      if (in_frame_end) begin
        pre_cnt <= '0;
        shift   <= '0;
        sym_cnt <= '0;
      end else begin
        pre_cnt <= pre_cnt_next;
        shift   <= shift_next;
        sym_cnt <= sym_cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lcsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcsd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lcsd_pkg::sym_event_t  wr_data,
  input  wire logic                  pop,
  output lcsd_pkg::sym_event_t       rd_data,
  output logic                       full,
  output logic                       empty
);

  lcsd_pkg::sym_event_t              mem [lcsd_pkg::QUEUE_DEPTH];
  logic [lcsd_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [lcsd_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [lcsd_pkg::QUEUE_CW-1:0]     fill;
  logic                              do_push;
  logic                              do_pop;

  assign full    = fill == lcsd_pkg::QUEUE_CW'(lcsd_pkg::QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/lcsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcsd_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [lcsd_pkg::MAX_FRAME_W-1:0] max_frame_bytes,
  input  wire logic                             q_empty,
  input  wire lcsd_pkg::sym_event_t             q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            out_data_byte,
  output logic                                  out_byte_valid,
  output logic                                  out_frame_done,
  output logic [1:0]                            out_status
);

  logic [lcsd_pkg::MAX_FRAME_W-1:0] bytes_out;
  logic [lcsd_pkg::MAX_FRAME_W-1:0] bytes_out_next;
  lcsd_pkg::status_t                first_error;
  lcsd_pkg::status_t                err_over;
  lcsd_pkg::status_t                err_code;
  lcsd_pkg::status_t                status_calc;
  lcsd_pkg::nibble_t                hi;
  lcsd_pkg::nibble_t                lo;
  logic                             code_bad;
  logic                             emit;
  logic                             has_out;
  logic [7:0]                       byte_calc;

  assign hi = lcsd_pkg::code_to_nibble(q_data.shift[9:5]);
  assign lo = lcsd_pkg::code_to_nibble(q_data.shift[4:0]);

  always_comb begin
    err_over = first_error;
    if (q_data.byte_start && (bytes_out >= max_frame_bytes) &&
        (first_error == lcsd_pkg::ST_OK)) begin
      err_over = lcsd_pkg::ST_OVER;
    end
    code_bad = q_data.pair_err || (q_data.done && q_data.is_4b5b && !(hi.hit && lo.hit));
    err_code = err_over;
    if (code_bad && (err_over == lcsd_pkg::ST_OK)) begin
      err_code = lcsd_pkg::ST_CODE;
    end
    emit           = q_data.done && (err_code == lcsd_pkg::ST_OK);
    has_out        = emit || q_data.frame_end;
    bytes_out_next = emit ? bytes_out + 1'b1 : bytes_out;
    byte_calc      = q_data.is_4b5b ? {hi.nibble, lo.nibble} : q_data.shift[7:0];
    if (!q_data.frame_end) begin
      status_calc = lcsd_pkg::ST_OK;
    end else if (q_data.sync_bad) begin
      status_calc = lcsd_pkg::ST_SYNC;
    end else begin
      status_calc = err_code;
    end
  end

  // A record that yields no result drains even while the output register is held.
  assign q_pop = !q_empty && (!has_out || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_out   <= '0;
      first_error <= lcsd_pkg::ST_OK;
    end else if (q_pop) begin
      if (q_data.frame_end) begin
        bytes_out   <= '0;
        first_error <= lcsd_pkg::ST_OK;
      end else begin
        bytes_out   <= bytes_out_next;
        first_error <= err_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && has_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && has_out) begin
      out_data_byte  <= emit ? byte_calc : 8'd0;
      out_byte_valid <= emit;
      out_frame_done <= q_data.frame_end;
      out_status     <= status_calc;
    end
  end

endmodule

`default_nettype wire

// ===== design/line_code_symbol_decoder.sv =====
// Timing: a symbol request accepted at a clock edge is written to the queue at that edge,
// then the back end pops it into the output register, from which its result is taken.
// Throughput: one symbol per cycle unless stalled; the front end takes one request a cycle
// while the four-entry queue has room, and the back end while its output is not held.
// Reset (synchronous, rst high) empties the queue and output register, clears the frame
// state and sets line_mode to Manchester and max_frame_bytes to 256.
`timescale 1ns / 1ps
`default_nettype none

`include "line_code_symbol_decoder_macros.svh"

module line_code_symbol_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst,
  lcsd_sym_if.sink                                symbols,
  lcsd_res_if.source                              results,
  input  wire logic                               cfg_wr_en,
  input  wire logic [lcsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lcsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                             line_mode;
  logic [lcsd_pkg::MAX_FRAME_W-1:0] max_frame_bytes;
  logic                             q_push;
  logic                             q_pop;
  logic                             q_full;
  logic                             q_empty;
  lcsd_pkg::sym_event_t             q_wr;
  lcsd_pkg::sym_event_t             q_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode       <= lcsd_pkg::MODE_MANCHESTER;
      max_frame_bytes <= lcsd_pkg::MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lcsd_pkg::REG_LINE_MODE: line_mode       <= cfg_data[0];
        lcsd_pkg::REG_MAX_FRAME: max_frame_bytes <= cfg_data[lcsd_pkg::MAX_FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  lcsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .line_mode    (line_mode),
    .in_valid     (symbols.valid),
    .in_ready     (symbols.ready),
    .in_symbol    (symbols.symbol),
    .in_frame_end (symbols.frame_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wr)
  );

  lcsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  lcsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .max_frame_bytes (max_frame_bytes),
    .q_empty         (q_empty),
    .q_data          (q_rd),
    .q_pop           (q_pop),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_data_byte   (results.data_byte),
    .out_byte_valid  (results.byte_valid),
    .out_frame_done  (results.frame_done),
    .out_status      (results.status)
  );

  // A result that does not close a frame must carry a byte and a clear status.
  `LCSD_ASSERT_NOW(a_mid_frame_result, results.valid && !results.frame_done,
                   results.byte_valid && (results.status == lcsd_pkg::ST_OK))
  `LCSD_ASSERT_NOW(a_empty_byte_zero, results.valid && !results.byte_valid,
                   results.data_byte == 8'd0)
  `LCSD_ASSERT_NOW(a_full_stalls_input, q_full, !symbols.ready)
  `LCSD_ASSERT_NEXT(a_push_fills_queue, q_push && !q_pop, !q_empty)

endmodule

`default_nettype wire

// ===== sim/tb_line_code_symbol_decoder.sv =====
`timescale 1ns / 1ps

module tb_line_code_symbol_decoder;
  import lcsd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       frame_done;
    status_t    status;
  } decoded_t;

  // Tracks the decoder's frame state and holds the results still owed by the block.
  class decoded_byte_board;
    logic                   mode;
    logic [MAX_FRAME_W-1:0] max_bytes;
    int                     pre_seen;
    logic [SHIFT_W-1:0]     shift;
    int                     sym_cnt;
    logic [15:0]            bytes_out;
    status_t                first_err;
    decoded_t               expected_out[$];
    int                     errors;
    int                     checked;
    int                     bytes_seen;
    int                     status_seen[4];

    function new();
      mode      = MODE_MANCHESTER;
      max_bytes = MAX_FRAME_RESET;
      errors    = 0;
      checked   = 0;
      bytes_seen = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pre_seen  = 0;
      shift     = '0;
      sym_cnt   = 0;
      bytes_out = '0;
      first_err = ST_OK;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_LINE_MODE) mode = val[0];
      else if (idx == REG_MAX_FRAME) max_bytes = val[MAX_FRAME_W-1:0];
    endfunction

    function logic [4:0] code_of(logic [3:0] n);
      case (n)
        4'h0: return 5'h1e;
        4'h1: return 5'h09;
        4'h2: return 5'h14;
        4'h3: return 5'h15;
        4'h4: return 5'h0a;
        4'h5: return 5'h0b;
        4'h6: return 5'h0e;
        4'h7: return 5'h0f;
        4'h8: return 5'h12;
        4'h9: return 5'h13;
        4'ha: return 5'h16;
        4'hb: return 5'h17;
        4'hc: return 5'h1a;
        4'hd: return 5'h1b;
        4'he: return 5'h1c;
        default: return 5'h1d;
      endcase
    endfunction

    // Top bit set when the code is one of the sixteen data codes.
    function logic [4:0] nibble_of(logic [4:0] code);
      for (int k = 0; k < 16; k++) begin
        if (code_of(4'(k)) == code) return {1'b1, 4'(k)};
      end
      return 5'h00;
    endfunction

    function void record_error(status_t e);
      if (first_err == ST_OK) first_err = e;
    endfunction

    function void note_symbol(logic s, logic e);
      decoded_t   r;
      logic       done;
      logic       emit;
      logic [7:0] b;
      logic [4:0] hi;
      logic [4:0] lo;
      done = 1'b0;
      emit = 1'b0;
      b    = 8'h00;
      if (sym_cnt == 0 && bytes_out >= max_bytes) record_error(ST_OVER);
      if (pre_seen < PREAMBLE_SYMS) begin
        shift = {shift[SHIFT_W-2:0], s};
        pre_seen++;
        sym_cnt++;
        if (sym_cnt >= 8) begin
          b    = shift[7:0];
          done = 1'b1;
        end
      end else if (mode == MODE_MANCHESTER) begin
        // The first half of a pair waits in the top bit; the second half is the data bit.
        if (sym_cnt % 2 == 0) begin
          shift = {s, 1'b0, shift[7:0]};
        end else begin
          if (shift[9] == s) record_error(ST_CODE);
          shift = {2'b00, shift[6:0], s};
        end
        sym_cnt++;
        if (sym_cnt >= 16) begin
          b    = shift[7:0];
          done = 1'b1;
        end
      end else begin
        shift = {shift[SHIFT_W-2:0], s};
        sym_cnt++;
        if (sym_cnt >= 10) begin
          hi = nibble_of(shift[9:5]);
          lo = nibble_of(shift[4:0]);
          if (!hi[4] || !lo[4]) record_error(ST_CODE);
          else b = {hi[3:0], lo[3:0]};
          done = 1'b1;
        end
      end
      if (done) begin
        sym_cnt = 0;
        shift   = '0;
        if (first_err == ST_OK) begin
          emit      = 1'b1;
          bytes_out = bytes_out + 16'd1;
        end
      end
      if (emit || e) begin
        r.data_byte  = emit ? b : 8'h00;
        r.byte_valid = emit;
        r.frame_done = e;
        r.status     = ST_OK;
        if (e) begin
          if (pre_seen < PREAMBLE_SYMS || sym_cnt != 0) r.status = ST_SYNC;
          else r.status = first_err;
          clear_frame();
        end
        expected_out.push_back(r);
      end
    endfunction

    function void check_result(logic [7:0] d, logic bv, logic fd, logic [1:0] st);
      decoded_t x;
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, got byte %02h valid %0b done %0b st %0d",
                 $time, d, bv, fd, st);
        return;
      end
      x = expected_out.pop_front();
      checked++;
      if (x.data_byte !== d || x.byte_valid !== bv || x.frame_done !== fd ||
          x.status !== st) begin
        errors++;
        $display("%0t: mismatch, expected %02h v%0b d%0b s%0d, got %02h v%0b d%0b s%0d",
                 $time, x.data_byte, x.byte_valid, x.frame_done, x.status, d, bv, fd, st);
      end
      if (bv) bytes_seen++;
      if (fd) status_seen[st]++;
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lcsd_sym_if sym_bus ();
  lcsd_res_if res_bus ();

  line_code_symbol_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .symbols   (sym_bus),
    .results   (res_bus),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  decoded_byte_board board = new();
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   items_sent     = 0;
  logic mode_now       = MODE_MANCHESTER;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready)
        board.check_result(res_bus.data_byte, res_bus.byte_valid, res_bus.frame_done,
                           res_bus.status);
      res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_symbol(input logic s, input logic e);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      sym_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_bus.valid     <= 1'b1;
    sym_bus.symbol    <= s;
    sym_bus.frame_end <= e;
    do @(posedge clk); while (!sym_bus.ready);
    board.note_symbol(s, e);
    items_sent++;
  endtask

  // A symbol that causes no result may still be inside the block when the queue runs dry.
  task automatic wait_idle();
    int guard;
    guard = 0;
    sym_bus.valid <= 1'b0;
    while (board.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_register(idx, val);
    if (idx == REG_LINE_MODE) mode_now = val[0];
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame();
    logic       bits[$];
    int         pick;
    int         n_bytes;
    logic [7:0] v;
    logic [4:0] c;
    pick = $urandom_range(99);
    if (pick < 15) begin
      // Noise: a short run of random symbols, usually ending inside the preamble.
      repeat ($urandom_range(48, 1)) bits.push_back(1'($urandom_range(1)));
    end else begin
      repeat (PREAMBLE_SYMS) bits.push_back(1'($urandom_range(1)));
      n_bytes = $urandom_range(3);
      repeat (n_bytes) begin
        case ($urandom_range(9))
          0: v = 8'h00;
          1: v = 8'hff;
          default: v = 8'($urandom_range(255));
        endcase
        if (mode_now == MODE_MANCHESTER) begin
          for (int i = 7; i >= 0; i--) begin
            if ($urandom_range(99) < 3) begin
              bits.push_back(v[i]);
              bits.push_back(v[i]);
            end else begin
              bits.push_back(~v[i]);
              bits.push_back(v[i]);
            end
          end
        end else begin
          for (int h = 1; h >= 0; h--) begin
            c = board.code_of(h ? v[7:4] : v[3:0]);
            if ($urandom_range(99) < 4) c = 5'($urandom_range(31));
            for (int i = 4; i >= 0; i--) bits.push_back(c[i]);
          end
        end
      end
      if (pick < 30) repeat ($urandom_range(15, 1)) void'(bits.pop_back());
    end
    for (int i = 0; i < bits.size(); i++) send_symbol(bits[i], i == bits.size() - 1);
  endtask

  task automatic run_phase(input logic mode, input logic [MAX_FRAME_W-1:0] max_b,
                           input int src_pct, input int sink_pct, input int n_syms);
    int start;
    wait_idle();
    write_reg(REG_LINE_MODE, CFG_DATA_W'(mode));
    write_reg(REG_MAX_FRAME, max_b);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = items_sent;
    while (items_sent - start < n_syms) send_frame();
  endtask

  // The symbol count carries across the switch, so the first byte after it is a hybrid.
  task automatic switch_mode_mid_frame(input logic from_mode, input logic to_mode,
                                       input int partial);
    wait_idle();
    write_reg(REG_LINE_MODE, CFG_DATA_W'(from_mode));
    repeat (PREAMBLE_SYMS + partial) send_symbol(1'($urandom_range(1)), 1'b0);
    wait_idle();
    write_reg(REG_LINE_MODE, CFG_DATA_W'(to_mode));
    for (int i = 0; i < 16; i++) send_symbol(1'($urandom_range(1)), i == 15);
  endtask

  initial begin
    rst               = 1'b1;
    sym_bus.valid     = 1'b0;
    sym_bus.symbol    = 1'b0;
    sym_bus.frame_end = 1'b0;
    res_bus.ready     = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_LINE_MODE;
    cfg_data          = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Frame closed on its very first symbol, then a byte completed by the closing symbol.
    send_symbol(1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_symbol(1'b1, i == 7);
    // A zero byte limit overflows on the first preamble byte.
    wait_idle();
    write_reg(REG_MAX_FRAME, '0);
    for (int i = 0; i < 8; i++) send_symbol(1'b0, i == 7);

    run_phase(MODE_MANCHESTER, 16'hffff, 0, 0, 50);
    switch_mode_mid_frame(MODE_MANCHESTER, MODE_4B5B, 12);
    run_phase(MODE_4B5B, 16'd5, 50, 0, 50);
    run_phase(MODE_MANCHESTER, 16'd6, 0, 50, 50);
    switch_mode_mid_frame(MODE_4B5B, MODE_MANCHESTER, $urandom_range(9, 1));
    run_phase(MODE_4B5B, 16'hffff, 35, 35, 50);
    run_phase(MODE_MANCHESTER, 16'd1, 35, 35, 30);
    run_phase(MODE_4B5B, 16'd256, 0, 0, 40);

    wait_idle();
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d expected results never arrived", $time, board.pending());
    end
    $display("Sent %0d symbols; checked %0d results carrying %0d decoded bytes.",
             items_sent, board.checked, board.bytes_seen);
    $display("Frames closed: %0d ok, %0d sync, %0d line code, %0d overflow.",
             board.status_seen[ST_OK], board.status_seen[ST_SYNC],
             board.status_seen[ST_CODE], board.status_seen[ST_OVER]);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== line_code_symbol_decoder.f =====
+incdir+design
design/lcsd_pkg.sv
design/lcsd_sym_if.sv
design/lcsd_res_if.sv
design/lcsd_front.sv
design/lcsd_queue.sv
design/lcsd_back.sv
design/line_code_symbol_decoder.sv
sim/tb_line_code_symbol_decoder.sv
